@@ rtl/core/wsp_pkg.sv @@
// Shared types and constants for the WAV sample to PCM16 converter.
// Used by the controller, the datapath and the top level.
package wsp_pkg;

  localparam int Q_W   = 42;
  localparam int SUM_W = 45;
  localparam int T_W   = 20;
  localparam int CNT_W = 5;

  localparam logic [2:0] FMT_U8  = 3'd0;
  localparam logic [2:0] FMT_S16 = 3'd1;
  localparam logic [2:0] FMT_S24 = 3'd2;
  localparam logic [2:0] FMT_S32 = 3'd3;
  localparam logic [2:0] FMT_F32 = 3'd4;

  localparam logic [1:0] REG_FORMAT   = 2'd0;
  localparam logic [1:0] REG_CHANNELS = 2'd1;

  localparam logic [40:0] Q_ONE = 41'd1 << 40;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ACCUM,
    S_DIVIDE,
    S_OUTPUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic accum;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic produce;
    logic direct;
    logic div_last;
    logic out_free;
  } status_t;

  function automatic logic signed [Q_W-1:0] decode_sample(input logic [2:0] fmt,
                                                          input logic [31:0] w);
    logic [7:0] ex;
    logic [7:0] e;
    logic [23:0] man;
    logic [40:0] mag;
    logic signed [Q_W-1:0] r;
    ex  = w[30:23];
    e   = (ex == 8'd0) ? 8'd1 : ex;
    man = {(ex != 8'd0), w[22:0]};
    mag = '0;
    r   = '0;
    unique case (fmt)
      FMT_U8:  r = Q_W'(signed'({~w[7], w[6:0]})) <<< 33;
      FMT_S16: r = Q_W'($signed(w[15:0])) <<< 25;
      FMT_S24: r = Q_W'($signed(w[23:0])) <<< 17;
      FMT_S32: r = Q_W'($signed(w[31:0])) <<< 9;
      FMT_F32: begin
        if (ex == 8'hFF) begin
          r = '0;
        end else begin
          if (e >= 8'd127) begin
            mag = Q_ONE;
          end else if (e >= 8'd110) begin
            mag = 41'(man) << (e - 8'd110);
          end else begin
            mag = 41'(man) >> (8'd110 - e);
          end
          r = w[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/wav_sample_to_pcm16_converter_top.sv @@
// Top level: WAV sample words in, signed 16-bit PCM beats out.
// Instantiates wsp_controller and wsp_datapath; uses wsp_pkg.
// Path: capture, decode, accumulate, then output; the last beat of a downmix
// frame runs the 20-step serial divider before output (mean of the channels).
// Beats that end no result go back to idle after accumulate. One beat is in
// flight at a time; output waits while the output register holds a beat.
// Reset (rst, synchronous): format 16-bit, 2 channels, frame state cleared.
module wav_sample_to_pcm16_converter_top #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] sample_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [15:0] pcm_sample
  output logic        m_tuser,  // [0] output_channel
  output logic        m_tlast   // frame_done
);

  wsp_pkg::cmd_t    cmd;
  wsp_pkg::status_t status;

  assign cfg_ready = 1'b1;

  wsp_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  wsp_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("Input beat accepted while a sample is in flight.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !m_tvalid)
    else $error("Output register loaded while holding an untaken beat.");

  a_mono_channel: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && !status.direct) |=> !m_tuser && m_tlast)
    else $error("Downmix result must be channel zero and end the frame.");

endmodule

@@ rtl/core/wsp_controller.sv @@
// Sequencing state machine for the WAV sample to PCM16 converter.
// Depends on wsp_pkg for the state, command and status types.
module wsp_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  wsp_pkg::status_t status,
  output wsp_pkg::cmd_t    cmd
);

  wsp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wsp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wsp_pkg::S_IDLE: begin
        if (s_tvalid) state_next = wsp_pkg::S_DECODE;
      end
      wsp_pkg::S_DECODE: state_next = wsp_pkg::S_ACCUM;
      wsp_pkg::S_ACCUM: begin
        if (!status.produce) state_next = wsp_pkg::S_IDLE;
        else if (status.direct) state_next = wsp_pkg::S_OUTPUT;
        else state_next = wsp_pkg::S_DIVIDE;
      end
      wsp_pkg::S_DIVIDE: begin
        if (status.div_last) state_next = wsp_pkg::S_OUTPUT;
      end
      wsp_pkg::S_OUTPUT: begin
        if (status.out_free) state_next = wsp_pkg::S_IDLE;
      end
      default: state_next = wsp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      wsp_pkg::S_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      wsp_pkg::S_DECODE: cmd.decode = 1'b1;
      wsp_pkg::S_ACCUM:  cmd.accum = 1'b1;
      wsp_pkg::S_DIVIDE: cmd.div_step = 1'b1;
      wsp_pkg::S_OUTPUT: cmd.load_out = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/wsp_datapath.sv @@
// Datapath: configuration registers, sample decode, frame accumulator,
// serial divider for the downmix mean and the output register. Uses wsp_pkg.
module wsp_datapath #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [3:0]       cfg_data,
  input  logic [31:0]      s_tdata,
  input  wsp_pkg::cmd_t    cmd,
  output wsp_pkg::status_t status,
  input  logic             m_tready,
  output logic             m_tvalid,
  output logic [15:0]      m_tdata,
  output logic             m_tuser,
  output logic             m_tlast
);

  logic [2:0]                          sample_format;
  logic [3:0]                          channel_count;
  logic [3:0]                          position;
  logic signed [wsp_pkg::SUM_W-1:0]    frame_sum;
  logic [31:0]                         word;
  logic signed [wsp_pkg::Q_W-1:0]      q;
  logic [wsp_pkg::T_W-1:0]             t;
  logic [3:0]                          rem;
  logic [wsp_pkg::CNT_W-1:0]           cnt;
  logic                                neg;
  logic                                och;
  logic                                fdone;

  logic [3:0]                          n_eff;
  logic [3:0]                          pos_eff;
  logic [3:0]                          n_used;
  logic                                last;
  logic                                direct;
  logic signed [wsp_pkg::SUM_W-1:0]    acc;
  logic [wsp_pkg::SUM_W-1:0]           mag;
  logic [wsp_pkg::SUM_W-1:0]           rounded;
  logic [4:0]                          remx;
  logic [16:0]                         neg_mag;
  logic [15:0]                         pcm;

  always_comb begin
    if (channel_count == 4'd0) begin
      n_eff = 4'd1;
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      n_eff = 4'(MAX_CHANNELS);
    end else begin
      n_eff = channel_count;
    end
    pos_eff = (position >= n_eff) ? 4'd0 : position;
    last    = (pos_eff == n_eff - 4'd1);
    direct  = (n_eff <= 4'd2);
    n_used  = direct ? 4'd1 : n_eff;
    acc     = direct ? wsp_pkg::SUM_W'(q) : frame_sum + wsp_pkg::SUM_W'(q);
    mag     = acc[wsp_pkg::SUM_W-1] ? wsp_pkg::SUM_W'(-acc) : wsp_pkg::SUM_W'(acc);
    rounded = mag + wsp_pkg::SUM_W'({n_used, 24'd0});
    remx    = {rem, t[wsp_pkg::T_W-1]};
    neg_mag = (t > wsp_pkg::T_W'(32768)) ? 17'd32768 : t[16:0];
    if (neg) begin
      pcm = 16'(17'd0 - neg_mag);
    end else begin
      pcm = (t > wsp_pkg::T_W'(32767)) ? 16'h7FFF : t[15:0];
    end
  end

  assign status.produce  = direct || last;
  assign status.direct   = direct;
  assign status.div_last = (cnt == wsp_pkg::CNT_W'(wsp_pkg::T_W - 1));
  assign status.out_free = !m_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= wsp_pkg::FMT_S16;
      channel_count <= 4'd2;
      position      <= 4'd0;
      frame_sum     <= '0;
    end else if (cfg_write) begin
      if (cfg_index == wsp_pkg::REG_FORMAT) begin
        sample_format <= cfg_data[2:0];
        position      <= 4'd0;
        frame_sum     <= '0;
      end else if (cfg_index == wsp_pkg::REG_CHANNELS) begin
        channel_count <= cfg_data;
        position      <= 4'd0;
        frame_sum     <= '0;
      end
    end else if (cmd.accum) begin
      if (!direct && !last) begin
        frame_sum <= acc;
        position  <= pos_eff + 4'd1;
      end else begin
        frame_sum <= '0;
        position  <= last ? 4'd0 : pos_eff + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) word <= s_tdata;
    if (cmd.decode) q <= wsp_pkg::decode_sample(sample_format, word);
    if (cmd.accum) begin
      neg   <= acc[wsp_pkg::SUM_W-1];
      t     <= rounded[wsp_pkg::SUM_W-1-:wsp_pkg::T_W];
      rem   <= 4'd0;
      cnt   <= '0;
      och   <= direct ? pos_eff[0] : 1'b0;
      fdone <= last;
    end else if (cmd.div_step) begin
      cnt <= cnt + 1'b1;
      if (remx >= {1'b0, n_eff}) begin
        rem <= 4'(remx - {1'b0, n_eff});
        t   <= {t[wsp_pkg::T_W-2:0], 1'b1};
      end else begin
        rem <= remx[3:0];
        t   <= {t[wsp_pkg::T_W-2:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      m_tdata <= pcm;
      m_tuser <= och;
      m_tlast <= fdone;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
